// ===== rtl/sensor_channel_fault_monitor_macros.svh =====
// Assertion macros shared by the fault monitor checker.
`ifndef SENSOR_CHANNEL_FAULT_MONITOR_MACROS_SVH
`define SENSOR_CHANNEL_FAULT_MONITOR_MACROS_SVH

// Checked only while the block is out of reset.
`define SCFM_ASSERT_ON(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scfm assertion failed");

// Checked at every edge, reset included.
`define SCFM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("scfm assertion failed during reset");

`endif

// ===== rtl/scfm_pkg.sv =====
// Shared constants and types of the sensor channel fault monitor.
package scfm_pkg;

  localparam int CHANNELS    = 8;
  localparam int SLOTS       = 8;
  localparam int IN_SAMPLE_W = 12;
  localparam int SAMPLE_BITS = 12;
  localparam int SMP_W       = (SAMPLE_BITS < IN_SAMPLE_W) ? SAMPLE_BITS : IN_SAMPLE_W;
  localparam int RUN_W       = 16;
  localparam int THR_W       = 12;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [RUN_W-1:0] RUN_MAX          = '1;
  localparam logic [RUN_W-1:0] SAT_LIMIT_RESET  = 16'd8;
  localparam logic [RUN_W-1:0] STUCK_LIMIT_RESET = 16'd125;
  localparam logic [THR_W-1:0] CHANGE_THR_RESET = 12'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAT_LIMIT   = 2'd0,
    CFG_STUCK_LIMIT = 2'd1,
    CFG_CHANGE_THR  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [RUN_W-1:0] sat_limit;
    logic [RUN_W-1:0] stuck_limit;
    logic [THR_W-1:0] change_thr;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic hist_valid;
  } lane_ctl_t;

  typedef struct packed {
    logic changed;
    logic fault;
  } lane_st_t;

endpackage

// ===== rtl/scfm_lane.sv =====
// One channel lane: change detection, saturated and unchanged run counters.
module scfm_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  scfm_pkg::cfg_t                cfg,
  input  scfm_pkg::lane_ctl_t           ctl,
  input  logic [scfm_pkg::SMP_W-1:0]    sample,
  input  logic                          fresh,
  input  logic                          saturated,
  input  logic                          others_changed,
  output scfm_pkg::lane_st_t            st
);

  logic [scfm_pkg::SMP_W-1:0] prev_r, prev_nxt;
  logic [scfm_pkg::RUN_W-1:0] sat_run_r, sat_run_nxt;
  logic [scfm_pkg::RUN_W-1:0] unch_run_r, unch_run_nxt;
  logic [scfm_pkg::SMP_W-1:0] gap;
  logic                       changed;
  logic                       refresh;

  assign gap     = (sample >= prev_r) ? (sample - prev_r) : (prev_r - sample);
  assign changed = ctl.hist_valid && fresh &&
                   (scfm_pkg::THR_W'(gap) > cfg.change_thr);
  // Every channel is refreshed on the first frame after reset.
  assign refresh = !ctl.hist_valid || fresh;

  always_comb begin
    prev_nxt     = prev_r;
    sat_run_nxt  = sat_run_r;
    unch_run_nxt = unch_run_r;
    if (refresh) begin
      prev_nxt = sample;
      if (saturated) begin
        if (sat_run_r != scfm_pkg::RUN_MAX) begin
          sat_run_nxt = sat_run_r + 1'b1;
        end
      end else begin
        sat_run_nxt = '0;
      end
      if (!ctl.hist_valid || changed) begin
        unch_run_nxt = '0;
      end else if (others_changed && (unch_run_r != scfm_pkg::RUN_MAX)) begin
        unch_run_nxt = unch_run_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      sat_run_r  <= '0;
      unch_run_r <= '0;
    end else if (ctl.accept) begin
      prev_r     <= prev_nxt;
      sat_run_r  <= sat_run_nxt;
      unch_run_r <= unch_run_nxt;
    end
  end

  assign st.changed = changed;
  assign st.fault   = (sat_run_nxt >= cfg.sat_limit) || (unch_run_nxt >= cfg.stuck_limit);

endmodule

// ===== rtl/scfm_merge.sv =====
// Merging stage: cross-lane change flags and the combined fault masks.
module scfm_merge (
  input  scfm_pkg::lane_st_t              st [scfm_pkg::CHANNELS],
  input  logic [scfm_pkg::SLOTS-1:0]      cal_bits,
  output logic [scfm_pkg::CHANNELS-1:0]   others_changed,
  output logic [scfm_pkg::SLOTS-1:0]      runtime_bits,
  output logic [scfm_pkg::SLOTS-1:0]      anomaly_bits
);

  logic [scfm_pkg::CHANNELS-1:0] changed_vec;
  logic [scfm_pkg::CHANNELS-1:0] fault_vec;

  always_comb begin
    for (int i = 0; i < scfm_pkg::CHANNELS; i++) begin
      changed_vec[i] = st[i].changed;
      fault_vec[i]   = st[i].fault;
    end
    // A lane's unchanged run counter advances only when some other lane moved.
    for (int i = 0; i < scfm_pkg::CHANNELS; i++) begin
      others_changed[i] = |(changed_vec & ~(scfm_pkg::CHANNELS'(1) << i));
    end
  end

  // Unmonitored slots report no runtime fault.
  assign runtime_bits = scfm_pkg::SLOTS'(fault_vec);
  assign anomaly_bits = runtime_bits | cal_bits;

endmodule

// ===== rtl/sensor_channel_fault_monitor.sv =====
// Top level of the sensor channel fault monitor.
// A word accepted in one cycle shows on the output in the cycle after it.
// Throughput: one word per cycle unless out_ready stalls; all channel lanes update their
// run counters in the accepting cycle and the result sits in a single output register.
// A new word is taken whenever the output register is empty or being drained.
// Reset (synchronous, rst_n low) clears all counters, stored samples and history,
// empties the output register and loads the register reset values.
module sensor_channel_fault_monitor (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch0,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch1,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch2,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch3,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch4,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch5,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch6,
  input  logic [scfm_pkg::IN_SAMPLE_W-1:0]   in_sample_ch7,
  input  logic [scfm_pkg::SLOTS-1:0]         in_fresh_bits,
  input  logic [scfm_pkg::SLOTS-1:0]         in_saturated_bits,
  input  logic [scfm_pkg::SLOTS-1:0]         in_calibration_fault_bits,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [scfm_pkg::SLOTS-1:0]         out_runtime_fault_bits,
  output logic [scfm_pkg::SLOTS-1:0]         out_anomaly_bits,
  input  logic                               cfg_wr_en,
  input  logic [scfm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scfm_pkg::CFG_W-1:0]         cfg_wdata
);

  scfm_pkg::cfg_t                       cfg_r;
  scfm_pkg::lane_ctl_t                  ctl;
  scfm_pkg::lane_st_t                   st [scfm_pkg::CHANNELS];
  logic [scfm_pkg::IN_SAMPLE_W-1:0]     smp [scfm_pkg::SLOTS];
  logic [scfm_pkg::CHANNELS-1:0]        others_changed;
  logic [scfm_pkg::SLOTS-1:0]           runtime_bits;
  logic [scfm_pkg::SLOTS-1:0]           anomaly_bits;
  logic                                 hist_valid_r;
  logic                                 out_valid_r;
  logic [scfm_pkg::SLOTS-1:0]           runtime_r;
  logic [scfm_pkg::SLOTS-1:0]           anomaly_r;
  logic                                 in_acc;

  assign smp[0] = in_sample_ch0;
  assign smp[1] = in_sample_ch1;
  assign smp[2] = in_sample_ch2;
  assign smp[3] = in_sample_ch3;
  assign smp[4] = in_sample_ch4;
  assign smp[5] = in_sample_ch5;
  assign smp[6] = in_sample_ch6;
  assign smp[7] = in_sample_ch7;

  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  assign ctl.accept     = in_acc;
  assign ctl.hist_valid = hist_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sat_limit   <= scfm_pkg::SAT_LIMIT_RESET;
      cfg_r.stuck_limit <= scfm_pkg::STUCK_LIMIT_RESET;
      cfg_r.change_thr  <= scfm_pkg::CHANGE_THR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        scfm_pkg::CFG_SAT_LIMIT:   cfg_r.sat_limit   <= cfg_wdata;
        scfm_pkg::CFG_STUCK_LIMIT: cfg_r.stuck_limit <= cfg_wdata;
        scfm_pkg::CFG_CHANGE_THR:  cfg_r.change_thr  <= cfg_wdata[scfm_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < scfm_pkg::CHANNELS; g++) begin : g_lane
    scfm_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .cfg            (cfg_r),
      .ctl            (ctl),
      .sample         (smp[g][scfm_pkg::SMP_W-1:0]),
      .fresh          (in_fresh_bits[g]),
      .saturated      (in_saturated_bits[g]),
      .others_changed (others_changed[g]),
      .st             (st[g])
    );
  end

  scfm_merge u_merge (
    .st             (st),
    .cal_bits       (in_calibration_fault_bits),
    .others_changed (others_changed),
    .runtime_bits   (runtime_bits),
    .anomaly_bits   (anomaly_bits)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_acc) begin
        hist_valid_r <= 1'b1;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      runtime_r <= runtime_bits;
      anomaly_r <= anomaly_bits;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_runtime_fault_bits = runtime_r;
  assign out_anomaly_bits       = anomaly_r;

endmodule

// ===== rtl/scfm_checker.sv =====
// Port-level checker of the sensor channel fault monitor and its bind.
`include "sensor_channel_fault_monitor_macros.svh"

module scfm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [scfm_pkg::SLOTS-1:0]    out_runtime_fault_bits,
  input logic [scfm_pkg::SLOTS-1:0]    out_anomaly_bits
);

  // Every runtime fault also shows as an anomaly.
  `SCFM_ASSERT_ON(a_anomaly_covers, out_valid |-> ((out_runtime_fault_bits & ~out_anomaly_bits) == '0))
  // An accepted word always produces a result on the next cycle.
  `SCFM_ASSERT_ON(a_accept_to_out, (in_valid && in_ready) |=> out_valid)
  // An empty output register never blocks the input.
  `SCFM_ASSERT_ON(a_ready_when_empty, !out_valid |-> in_ready)
  `SCFM_ASSERT_ON(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_anomaly_bits)))
  `SCFM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid)

endmodule

bind sensor_channel_fault_monitor scfm_checker u_scfm_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_ready               (in_ready),
  .out_valid              (out_valid),
  .out_ready              (out_ready),
  .out_runtime_fault_bits (out_runtime_fault_bits),
  .out_anomaly_bits       (out_anomaly_bits)
);

// ===== tb/sensor_channel_fault_monitor_tb.sv =====
// Self-checking testbench of the sensor channel fault monitor: directed, random and soak frames.
`timescale 1ns / 1ps

module sensor_channel_fault_monitor_tb;

  localparam int MAX_SAMPLE     = (1 << scfm_pkg::IN_SAMPLE_W) - 1;
  localparam int RAND_PHASES    = 6;
  localparam int RAND_PER_PHASE = 65;
  localparam int SOAK_FRAMES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRINT_CAP      = 200;
  localparam logic [scfm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [scfm_pkg::SLOTS-1:0][scfm_pkg::IN_SAMPLE_W-1:0] smp;
    logic [scfm_pkg::SLOTS-1:0]                            fresh;
    logic [scfm_pkg::SLOTS-1:0]                            sat;
    logic [scfm_pkg::SLOTS-1:0]                            cal;
  } frame_t;

  typedef struct packed {
    logic [scfm_pkg::SLOTS-1:0] runtime;
    logic [scfm_pkg::SLOTS-1:0] anomaly;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  frame_t cur_frame = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [scfm_pkg::SLOTS-1:0] out_runtime_fault_bits;
  logic [scfm_pkg::SLOTS-1:0] out_anomaly_bits;
  logic cfg_wr_en = 1'b0;
  logic [scfm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [scfm_pkg::CFG_W-1:0] cfg_wdata = '0;

  // Stimulus and checking bookkeeping.
  frame_t frame_queue[$];
  verdict_t pending_verdicts[$];
  logic word_taken = 1'b0;
  bit idle_enable = 1'b1;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  logic [scfm_pkg::IN_SAMPLE_W-1:0] gen_last [scfm_pkg::SLOTS] = '{default: '0};

  // Predictor state and register shadow.
  logic [scfm_pkg::IN_SAMPLE_W-1:0] last_sample [scfm_pkg::SLOTS] = '{default: '0};
  logic [scfm_pkg::RUN_W-1:0] sat_run [scfm_pkg::SLOTS] = '{default: '0};
  logic [scfm_pkg::RUN_W-1:0] still_run [scfm_pkg::SLOTS] = '{default: '0};
  bit have_history = 1'b0;
  logic [scfm_pkg::RUN_W-1:0] lim_sat = scfm_pkg::SAT_LIMIT_RESET;
  logic [scfm_pkg::RUN_W-1:0] lim_stuck = scfm_pkg::STUCK_LIMIT_RESET;
  logic [scfm_pkg::THR_W-1:0] thr_change = scfm_pkg::CHANGE_THR_RESET;

  sensor_channel_fault_monitor dut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_ready                  (in_ready),
    .in_sample_ch0             (cur_frame.smp[0]),
    .in_sample_ch1             (cur_frame.smp[1]),
    .in_sample_ch2             (cur_frame.smp[2]),
    .in_sample_ch3             (cur_frame.smp[3]),
    .in_sample_ch4             (cur_frame.smp[4]),
    .in_sample_ch5             (cur_frame.smp[5]),
    .in_sample_ch6             (cur_frame.smp[6]),
    .in_sample_ch7             (cur_frame.smp[7]),
    .in_fresh_bits             (cur_frame.fresh),
    .in_saturated_bits         (cur_frame.sat),
    .in_calibration_fault_bits (cur_frame.cal),
    .out_valid                 (out_valid),
    .out_ready                 (out_ready),
    .out_runtime_fault_bits    (out_runtime_fault_bits),
    .out_anomaly_bits          (out_anomaly_bits),
    .cfg_wr_en                 (cfg_wr_en),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Updates the channel run counters for one frame and returns the fault masks it yields.
  function automatic verdict_t predict_fault_mask(frame_t f);
    logic [scfm_pkg::SLOTS-1:0] moved;
    logic [scfm_pkg::SLOTS-1:0] others;
    logic [scfm_pkg::SLOTS-1:0] flt;
    logic [scfm_pkg::IN_SAMPLE_W-1:0] gap;
    moved = '0;
    flt = '0;
    for (int i = 0; i < scfm_pkg::SLOTS; i++) begin
      gap = (f.smp[i] >= last_sample[i]) ? f.smp[i] - last_sample[i]
                                         : last_sample[i] - f.smp[i];
      if (i < scfm_pkg::CHANNELS && have_history && f.fresh[i] && gap > thr_change) begin
        moved[i] = 1'b1;
      end
    end
    for (int i = 0; i < scfm_pkg::SLOTS; i++) begin
      if (i < scfm_pkg::CHANNELS) begin
        if (!have_history || f.fresh[i]) begin
          if (f.sat[i]) begin
            if (sat_run[i] != scfm_pkg::RUN_MAX) sat_run[i] = sat_run[i] + 1'b1;
          end else begin
            sat_run[i] = '0;
          end
          others = moved;
          others[i] = 1'b0;
          if (!have_history || moved[i]) begin
            still_run[i] = '0;
          end else if (others != '0 && still_run[i] != scfm_pkg::RUN_MAX) begin
            still_run[i] = still_run[i] + 1'b1;
          end
          last_sample[i] = f.smp[i];
        end
        if (sat_run[i] >= lim_sat || still_run[i] >= lim_stuck) flt[i] = 1'b1;
      end
    end
    have_history = 1'b1;
    return '{runtime: flt, anomaly: flt | f.cal};
  endfunction

  function automatic frame_t make_frame(int base, int step, logic [scfm_pkg::SLOTS-1:0] fresh,
                                        logic [scfm_pkg::SLOTS-1:0] sat,
                                        logic [scfm_pkg::SLOTS-1:0] cal);
    frame_t f;
    for (int i = 0; i < scfm_pkg::SLOTS; i++) begin
      f.smp[i] = scfm_pkg::IN_SAMPLE_W'(base + i * step);
    end
    f.fresh = fresh;
    f.sat = sat;
    f.cal = cal;
    return f;
  endfunction

  // Each channel either holds, moves near the threshold, or jumps anywhere, so that
  // stuck and changed channels mix within one frame.
  function automatic frame_t random_frame(logic [scfm_pkg::SLOTS-1:0] sat_bias);
    frame_t f;
    int v;
    int span;
    span = int'(thr_change) + 2;
    for (int i = 0; i < scfm_pkg::SLOTS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: v = int'(gen_last[i]);
        4, 5, 6: v = int'(gen_last[i]) + int'($urandom_range(0, 2 * span)) - span;
        default: v = int'($urandom_range(0, MAX_SAMPLE));
      endcase
      if (v < 0) v = 0;
      if (v > MAX_SAMPLE) v = MAX_SAMPLE;
      f.smp[i] = scfm_pkg::IN_SAMPLE_W'(v);
      gen_last[i] = f.smp[i];
    end
    f.fresh = ($urandom_range(0, 2) == 0) ? scfm_pkg::SLOTS'($urandom)
                                          : scfm_pkg::SLOTS'($urandom | $urandom);
    f.sat = ($urandom_range(0, 3) == 0) ? scfm_pkg::SLOTS'($urandom) : sat_bias;
    f.cal = scfm_pkg::SLOTS'($urandom);
    return f;
  endfunction

  function automatic logic [scfm_pkg::CFG_W-1:0] pick_limit();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return scfm_pkg::RUN_MAX;
      2: return scfm_pkg::CFG_W'($urandom);
      default: return scfm_pkg::CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [scfm_pkg::CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return scfm_pkg::CFG_W'(MAX_SAMPLE);
      2: return scfm_pkg::CFG_W'($urandom);
      default: return scfm_pkg::CFG_W'($urandom_range(0, 40));
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic write_reg(logic [scfm_pkg::CFG_IDX_W-1:0] idx,
                           logic [scfm_pkg::CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      scfm_pkg::CFG_SAT_LIMIT:   lim_sat = val;
      scfm_pkg::CFG_STUCK_LIMIT: lim_stuck = val;
      scfm_pkg::CFG_CHANGE_THR:  thr_change = val[scfm_pkg::THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // The sender is empty when seen at a rising edge; the result store is checked at
  // the falling edge after it, once the monitor has taken that edge's results.
  task automatic wait_drained();
    bit quiet;
    quiet = 1'b0;
    while (!quiet) begin
      @(posedge clk);
      quiet = (frame_queue.size() == 0) && !in_valid;
      @(negedge clk);
      quiet = quiet && (pending_verdicts.size() == 0);
    end
  endtask

  // Driver: presents queued frames, with random gaps between words while idling is enabled.
  always @(negedge clk) begin
    logic nxt_valid;
    frame_t nxt;
    nxt_valid = in_valid;
    nxt = cur_frame;
    if (in_valid && word_taken) nxt_valid = 1'b0;
    if (!nxt_valid && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (frame_queue.size() > 0) begin
        if (idle_enable && $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(0, 12);
        end else begin
          nxt = frame_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
    end
    in_valid <= nxt_valid;
    cur_frame <= nxt;
  end

  // Result sink: holds ready low in random bursts while idling is enabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: checks each result, then predicts for the word taken at this edge.
  always @(posedge clk) begin
    verdict_t want;
    word_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %h/%h with nothing expected",
                                    out_runtime_fault_bits, out_anomaly_bits));
        end else begin
          want = pending_verdicts.pop_front();
          if (out_runtime_fault_bits !== want.runtime) begin
            report_mismatch($sformatf("runtime fault bits %h, expected %h",
                                      out_runtime_fault_bits, want.runtime));
          end
          if (out_anomaly_bits !== want.anomaly) begin
            report_mismatch($sformatf("anomaly bits %h, expected %h",
                                      out_anomaly_bits, want.anomaly));
          end
        end
      end
      if (in_valid && in_ready) pending_verdicts.push_back(predict_fault_mask(cur_frame));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sensor_channel_fault_monitor_tb failed");
      $finish;
    end
  end

  initial begin
    frame_t f;
    logic [scfm_pkg::SLOTS-1:0] bias;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset limits: the first frame refreshes every channel regardless of fresh bits,
    // then eight saturated frames reach the default saturation limit.
    frame_queue.push_back(make_frame(MAX_SAMPLE, 0, 8'h00, 8'hFF, 8'h00));
    for (int k = 0; k < 8; k++) begin
      frame_queue.push_back(make_frame(k * 500, 7, 8'hFF, 8'hFF, 8'h00));
    end
    frame_queue.push_back(make_frame(0, 0, 8'h00, 8'h00, 8'hFF));
    frame_queue.push_back(make_frame(0, 0, 8'hFF, 8'h00, 8'h00));
    f = make_frame(0, 0, 8'hFF, 8'h00, 8'h00);
    f.smp[3] = scfm_pkg::IN_SAMPLE_W'(MAX_SAMPLE);
    frame_queue.push_back(f);
    wait_drained();

    // A full-scale step does not exceed a full-scale threshold; the spare index is ignored.
    write_reg(scfm_pkg::CFG_SAT_LIMIT, 16'd1);
    write_reg(scfm_pkg::CFG_STUCK_LIMIT, 16'd2);
    write_reg(scfm_pkg::CFG_CHANGE_THR, scfm_pkg::CFG_W'(MAX_SAMPLE));
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    frame_queue.push_back(make_frame(MAX_SAMPLE, 0, 8'hFF, 8'h00, 8'h00));
    frame_queue.push_back(make_frame(0, 0, 8'hFF, 8'h00, 8'h00));
    wait_drained();

    write_reg(scfm_pkg::CFG_CHANGE_THR, scfm_pkg::CFG_W'(MAX_SAMPLE - 1));
    frame_queue.push_back(make_frame(MAX_SAMPLE, 0, 8'h0F, 8'h01, 8'h00));
    frame_queue.push_back(make_frame(MAX_SAMPLE, 0, 8'hFF, 8'h00, 8'h00));
    frame_queue.push_back(make_frame(0, 0, 8'hF0, 8'h00, 8'h00));
    frame_queue.push_back(make_frame(MAX_SAMPLE, 0, 8'hF0, 8'h00, 8'h00));
    wait_drained();

    // Zero limits are always reached.
    write_reg(scfm_pkg::CFG_SAT_LIMIT, 16'd0);
    write_reg(scfm_pkg::CFG_STUCK_LIMIT, 16'd0);
    frame_queue.push_back(random_frame(8'h00));
    frame_queue.push_back(random_frame(8'hFF));
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      write_reg(scfm_pkg::CFG_SAT_LIMIT, pick_limit());
      write_reg(scfm_pkg::CFG_STUCK_LIMIT, pick_limit());
      write_reg(scfm_pkg::CFG_CHANGE_THR, pick_threshold());
      if ($urandom_range(0, 2) == 0) write_reg(CFG_IDX_SPARE, scfm_pkg::CFG_W'($urandom));
      bias = scfm_pkg::SLOTS'($urandom);
      repeat (RAND_PER_PHASE) frame_queue.push_back(random_frame(bias));
      wait_drained();
    end

    // Back-to-back soak with no idling: channel 0 stays put while the others toggle
    // full scale every frame, so both run counters climb past their limits.
    idle_enable = 1'b0;
    write_reg(scfm_pkg::CFG_SAT_LIMIT, 16'd30);
    write_reg(scfm_pkg::CFG_STUCK_LIMIT, 16'd20);
    write_reg(scfm_pkg::CFG_CHANGE_THR, 16'd0);
    for (int k = 0; k < SOAK_FRAMES; k++) begin
      f = make_frame((k % 2 == 0) ? 0 : MAX_SAMPLE, 0, 8'hFF, 8'hFF, 8'h00);
      f.smp[0] = scfm_pkg::IN_SAMPLE_W'(100);
      frame_queue.push_back(f);
    end
    for (int k = 0; k < 4; k++) begin
      frame_queue.push_back(make_frame(100, 0, 8'hFF, 8'h00, 8'h5A));
    end
    wait_drained();

    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("sensor_channel_fault_monitor_tb passed");
    end else begin
      $display("sensor_channel_fault_monitor_tb failed");
    end
    $finish;
  end

endmodule
